// ----- hdl/prefix_varint_encoder_defines.svh -----
// assertion macros for the prefix varint encoder
// used by prefix_varint_encoder.sv; needs clk and rst_n in scope
`ifndef PREFIX_VARINT_ENCODER_DEFINES_SVH
`define PREFIX_VARINT_ENCODER_DEFINES_SVH

// plain check sampled on the rising edge, off during reset
`define PVE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication from one cycle to the next
`define PVE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/pve_pkg.sv -----
// shared types and constants for the prefix varint encoder
// no dependencies
package pve_pkg;

  localparam int VAL_W    = 64;
  localparam int OCTET_W  = 8;
  localparam int NUM_CELLS = 9;
  localparam int CNT_W    = 4;

  typedef logic [OCTET_W-1:0] octet_t;

  // one slot of the output chain
  typedef struct packed {
    logic   vld;
    logic   last;
    octet_t data;
  } pve_cell_t;

  // header byte with k leading ones
  localparam octet_t LEAD_ONES [0:8] = '{
    8'h00, 8'h80, 8'hC0, 8'hE0, 8'hF0, 8'hF8, 8'hFC, 8'hFE, 8'hFF
  };

endpackage

// ----- hdl/pve_cell.sv -----
// one slot of the output shift chain
// depends on pve_pkg
module pve_cell
  import pve_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  logic      shift,
  input  pve_cell_t ld_i,
  input  pve_cell_t nb_i,
  output pve_cell_t q_o
);

  logic   vld_r, vld_nxt;
  logic   last_r, last_nxt;
  octet_t data_r, data_nxt;

  always_comb begin
    vld_nxt  = vld_r;
    last_nxt = last_r;
    data_nxt = data_r;
    if (load) begin
      vld_nxt  = ld_i.vld;
      last_nxt = ld_i.last;
      data_nxt = ld_i.data;
    end else if (shift) begin
      vld_nxt  = nb_i.vld;
      last_nxt = nb_i.last;
      data_nxt = nb_i.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
    data_r <= data_nxt;
  end

  assign q_o = '{vld: vld_r, last: last_r, data: data_r};

endmodule

// ----- hdl/pve_fmt.sv -----
// builds the full byte image of one encoded value for a parallel load
// depends on pve_pkg
module pve_fmt
  import pve_pkg::*;
(
  input  logic [VAL_W-1:0] value,
  output pve_cell_t        cells [NUM_CELLS]
);

  logic [2:0]       nm1;      // significant bytes minus one, zero counts as one
  logic [CNT_W-1:0] n_eff;
  logic [VAL_W-1:0] shifted;
  octet_t           first;
  octet_t           hdr;
  octet_t           hdr_m;
  logic             merge;
  logic [CNT_W-1:0] cnt;
  octet_t           img [NUM_CELLS];

  always_comb begin
    nm1 = '0;
    for (int i = 0; i < 8; i++) begin
      if (value[8*i +: 8] != 8'h00) begin
        nm1 = 3'(i);
      end
    end
  end

  assign n_eff   = {1'b0, nm1} + 4'd1;
  assign shifted = value << {3'd7 - nm1, 3'b000};
  assign first   = shifted[63:56];
  assign hdr     = LEAD_ONES[n_eff];
  assign hdr_m   = LEAD_ONES[{1'b0, nm1}];
  assign merge   = ((hdr & first) == 8'h00);

  always_comb begin
    if (merge) begin
      img[0] = first | hdr_m;
      for (int k = 1; k < 8; k++) begin
        img[k] = shifted[63-8*k -: 8];
      end
      img[8] = 8'h00;
      cnt    = n_eff;
    end else begin
      img[0] = hdr;
      for (int k = 1; k < 9; k++) begin
        img[k] = shifted[71-8*k -: 8];
      end
      cnt = n_eff + 4'd1;
    end
  end

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_img
    assign cells[k].vld  = (4'(k) < cnt);
    assign cells[k].last = (4'(k) == cnt - 4'd1);
    assign cells[k].data = img[k];
  end

endmodule

// ----- hdl/prefix_varint_encoder.sv -----
// top level of the prefix-length unsigned varint encoder
// depends on pve_pkg, pve_fmt, pve_cell and prefix_varint_encoder_defines.svh
//
//   channel | ports                          | dir | handshake
//   --------+--------------------------------+-----+-------------------------
//   input   | in_value[63:0]                 | in  | in_valid / in_ready
//   result  | out_byte[7:0], out_last        | out | out_valid / out_ready
//
// a value that encodes to k bytes (1 to 9) holds the output chain until its last byte leaves,
// one byte leaving per cycle from the head cell while out_ready is high; the encoded byte count sets the rate
// the next item is taken in the same cycle as the last byte of the previous one
// leaves, so items stream with no gap between encodings
// the head cell is the output register; out_ready low freezes the whole chain
// synchronous active-low reset clears the cell valid bits only
`include "prefix_varint_encoder_defines.svh"

module prefix_varint_encoder
  import pve_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [VAL_W-1:0] in_value,
  output logic             out_valid,
  input  logic             out_ready,
  output octet_t           out_byte,
  output logic             out_last
);

  pve_cell_t ld_cells [NUM_CELLS];  // formatted image of the incoming item
  pve_cell_t q_cells  [NUM_CELLS];  // current chain contents, index 0 is the head
  pve_cell_t nb_cells [NUM_CELLS];  // what each cell takes on a shift
  logic      adv;
  logic      load;
  logic [NUM_CELLS-1:0] vld_vec;

  // byte image of the new value, computed straight from the input port
  pve_fmt u_fmt (
    .value (in_value),
    .cells (ld_cells)
  );

  // chain moves when the head is empty or being taken
  assign adv      = !q_cells[0].vld || out_ready;
  // free once at most the head byte remains and it leaves now
  assign in_ready = !q_cells[1].vld && adv;
  assign load     = in_valid && in_ready;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_chain
    if (k == NUM_CELLS - 1) begin : g_tail
      assign nb_cells[k] = '0;
    end else begin : g_mid
      assign nb_cells[k] = q_cells[k+1];
    end

    pve_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .load  (load),
      .shift (adv),
      .ld_i  (ld_cells[k]),
      .nb_i  (nb_cells[k]),
      .q_o   (q_cells[k])
    );

    assign vld_vec[k] = q_cells[k].vld;
  end

  assign out_valid = q_cells[0].vld;
  assign out_byte  = q_cells[0].data;
  assign out_last  = q_cells[0].last;

  // valid cells always form a run starting at the head
  `PVE_ASSERT(a_chain_packed, ((vld_vec & (vld_vec + 9'd1)) == '0), "chain has a gap")
  // a final byte at the head leaves nothing behind it
  `PVE_ASSERT(a_last_alone, (!(q_cells[0].vld && q_cells[0].last) || !q_cells[1].vld), "bytes after last")
  // a non-final head byte always has a successor queued
  `PVE_ASSERT(a_head_succ, (!(q_cells[0].vld && !q_cells[0].last) || q_cells[1].vld), "item cut short")
  // an accepted item shows its first byte on the next cycle
  `PVE_ASSERT_NEXT(a_load_show, load, out_valid, "accepted item not presented")

endmodule
